// File: rtl/mvbw_pkg.sv
// Shared types, constants and helpers of the minimum-variance blend weight block.
package mvbw_pkg;

    localparam int PIXEL_BITS            = 16;
    localparam int VAL_W                 = 16;
    localparam int WGT_W                 = 20;
    localparam int RANGE_W               = 17;
    localparam int CFG_W                 = 20;
    localparam int MUL_W                 = 32;
    localparam int WEIGHT_STEPS_DEF      = 101;
    localparam int MAX_VOXELS_LOG2_DEF   = 24;
    localparam int Q_ONE                 = 65536;
    localparam int MIN_SPAN              = 6554;
    localparam logic signed [21:0] PIX_MAX = 22'sd65535 >>> (16 - PIXEL_BITS);

    typedef enum logic [1:0] {
        CFG_RANGE_LOW,
        CFG_RANGE_HIGH,
        CFG_WEIGHT_START,
        CFG_WEIGHT_END
    } t_cfg_idx;

    typedef enum logic {
        REQ_MEASURE,
        REQ_APPLY
    } t_req;

    typedef enum logic {
        KIND_BLEND,
        KIND_REPORT
    } t_kind;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIV,
        ST_MPROD,
        ST_MSQ,
        ST_MWR,
        ST_MEND,
        ST_SRD,
        ST_S0,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_S4,
        ST_S5,
        ST_SCMP,
        ST_APROD,
        ST_ABLD,
        ST_EMIT
    } t_state;

    // trunc((b*65536 +/- p) / 65536), p = |a-b|*|w|
    function automatic logic signed [21:0] blend(input logic [VAL_W-1:0] b,
                                                 input logic [63:0] p,
                                                 input logic neg);
        logic signed [40:0] num;
        logic signed [40:0] term;
        logic [40:0]        mag;
        logic [24:0]        sh;
        term = $signed({1'b0, p[39:0]});
        num  = $signed({9'd0, b, 16'd0}) + (neg ? -term : term);
        mag  = num[40] ? 41'(-num) : 41'(num);
        sh   = mag[40:16];
        return num[40] ? 22'(-$signed({1'b0, sh})) : 22'(sh);
    endfunction

    function automatic logic signed [WGT_W-1:0] sat_weight(input logic signed [WGT_W-1:0] s,
                                                           input logic [20:0] q);
        logic signed [22:0] t;
        t = 23'(s) + $signed({2'b0, q});
        if (t > 23'sd524287) begin
            return 20'sd524287;
        end else if (t < -23'sd524288) begin
            return -20'sd524288;
        end
        return t[WGT_W-1:0];
    endfunction

endpackage

// File: rtl/mvbw_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
module mvbw_mul (
    input  logic                     i_clk,
    input  logic [mvbw_pkg::MUL_W-1:0] i_a,
    input  logic [mvbw_pkg::MUL_W-1:0] i_b,
    output logic [2*mvbw_pkg::MUL_W-1:0] o_p
);
    import mvbw_pkg::*;

    logic [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// File: rtl/mvbw_div.sv
// Divider of the sweep span by the constant lane count minus one, by reciprocal multiplication.
module mvbw_div #(
    parameter int DIVISOR = mvbw_pkg::WEIGHT_STEPS_DEF - 1,
    parameter int REM_W   = $clog2(DIVISOR + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mvbw_pkg::WGT_W-1:0] i_span,
    output logic                      o_done,
    output logic [mvbw_pkg::WGT_W-1:0] o_quo,
    output logic [REM_W-1:0]          o_rem
);
    import mvbw_pkg::*;

    // floor(x/D) == (x*M) >> SH for every x below 2^WGT_W, with M = ceil(2^SH/D)
    localparam int SH    = WGT_W + $clog2(DIVISOR);
    localparam int RCP_W = WGT_W + 2;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam logic [WGT_W-1:0] D = WGT_W'(DIVISOR);

    logic                   r_st1, r_st2, r_done;
    logic [WGT_W-1:0]       r_x, r_quo;
    logic [REM_W-1:0]       r_rem;
    logic [WGT_W+RCP_W-1:0] prod;
    logic [WGT_W-1:0]       back;

    assign prod = {{RCP_W{1'b0}}, r_x} * {{WGT_W{1'b0}}, RECIP};
    assign back = r_quo * D;

    // start: latch span; then quotient; then remainder and done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st1  <= 1'b0;
            r_st2  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_st1  <= i_start;
            r_st2  <= r_st1;
            r_done <= r_st2;
        end
        if (i_start) begin
            r_x <= i_span;
        end
        if (r_st1) begin
            r_quo <= WGT_W'(prod >> SH);
        end
        if (r_st2) begin
            r_rem <= REM_W'(r_x - back);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// File: rtl/min_variance_blend_weight.sv
// Minimum-variance blend weight finder and blender, top level.
//
// Input stream (s_axis): tdata = first_value, second_value, in_mask; tuser = req_type
// (0 measure, 1 apply); tlast = last voxel of the measure pass. The block takes one
// request at a time; tready is high only while it is idle.
// Output stream (m_axis): tdata = blended_value, chosen_weight, chosen_index;
// tuser = out_kind. One result per apply request and per last measure request.
// Config channel: i_cfg_index selects range_low, range_high, weight_start,
// weight_end; always ready; write only while idle.
// Sequencing, set by the one shared multiplier and the lane memories:
//   apply: product, blend, then the output register.
//   measure, not qualifying: the reciprocal span divide only.
//   measure, qualifying: the divide, then product, square and write per lane.
//   last measure: plus the report and, with voxels, a variance search
//   over every weight lane.
// Reset clears all lanes (valid bits), the count, and restores weight one.
// A result waits in the output register while the receiver stalls; the next
// result is held back until that register empties.
module min_variance_blend_weight #(
    parameter int WEIGHT_STEPS    = mvbw_pkg::WEIGHT_STEPS_DEF,
    parameter int MAX_VOXELS_LOG2 = mvbw_pkg::MAX_VOXELS_LOG2_DEF,
    parameter int IDX_W           = $clog2(WEIGHT_STEPS + 1),
    parameter int OUT_W           = ((36 + IDX_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [15:0] first_value, [31:16] second_value, [32] in_mask, [39:33] zero
    input  logic [39:0]           i_s_axis_tdata,
    // [0] req_type
    input  logic                  i_s_axis_tuser,
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [15:0] blended_value, [35:16] chosen_weight, then chosen_index, zero fill
    output logic [OUT_W-1:0]      o_m_axis_tdata,
    // [0] out_kind
    output logic                  o_m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [mvbw_pkg::CFG_W-1:0] i_cfg_data
);
    import mvbw_pkg::*;

    localparam int K_W    = $clog2(WEIGHT_STEPS);
    localparam int DIV_D  = WEIGHT_STEPS - 1;
    localparam int REM_W  = $clog2(DIV_D + 1);
    localparam int CNT_W  = MAX_VOXELS_LOG2 + 1;
    localparam int SUM_W  = 21 + MAX_VOXELS_LOG2;
    localparam int AW1    = CNT_W + 64;
    localparam int AW2    = 2 * SUM_W;
    localparam int ACC_W  = ((AW1 > AW2) ? AW1 : AW2) + 1;
    localparam logic [K_W-1:0] K_LAST = K_W'(WEIGHT_STEPS - 1);
    localparam logic signed [SUM_W:0] SUM_HI = (SUM_W + 1)'((65'd1 << (SUM_W - 1)) - 65'd1);
    localparam logic signed [SUM_W:0] SUM_LO = -SUM_HI - (SUM_W + 1)'(1);

    // configuration
    logic [RANGE_W-1:0]      r_lo, r_hi;
    logic signed [WGT_W-1:0] r_ws, r_we;

    // control
    t_state r_state, n_state;
    logic [K_W-1:0] r_k;
    logic [CNT_W-1:0] r_cnt;
    logic r_qual, r_last, r_neg;
    logic [VAL_W-1:0] r_a, r_b;

    // weight sweep
    logic [WGT_W-1:0]        r_q0;
    logic [REM_W-1:0]        r_r0, r_wr;
    logic [20:0]             r_wq;
    logic signed [WGT_W-1:0] r_w, r_sel_w;

    // lane memories
    logic [SUM_W-1:0] mem_sum [WEIGHT_STEPS];
    logic [63:0]      mem_sq  [WEIGHT_STEPS];
    logic [WEIGHT_STEPS-1:0] r_vld;
    logic [SUM_W-1:0] r_rs;
    logic [63:0]      r_rq;
    logic             r_rv;
    logic             rd_en, wr_en;
    logic [SUM_W-1:0] rs_eff, wr_sum;
    logic [63:0]      rq_eff, wr_sq;

    // datapath
    logic signed [21:0]   r_v;
    logic [SUM_W-1:0]     r_mag;
    logic signed [ACC_W-1:0] r_acc;
    logic [ACC_W-2:0]     r_best, spread;
    logic [K_W-1:0]       r_best_k;
    logic signed [WGT_W-1:0] r_best_w;
    logic                 better;

    // pending result and output register
    t_kind              r_res_kind, r_out_kind;
    logic [VAL_W-1:0]   r_res_blend, r_out_blend;
    logic [WGT_W-1:0]   r_res_w, r_out_w;
    logic [IDX_W-1:0]   r_res_idx, r_out_idx;
    logic               r_out_valid;

    // shared units
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [63:0]        prod;
    logic               div_start, div_done;
    logic [WGT_W-1:0]   div_quo, span;
    logic [REM_W-1:0]   div_rem;
    logic signed [20:0] span_raw;

    logic               s_acc;
    logic signed [16:0] diff;
    logic [16:0]        absd;
    logic [WGT_W-1:0]   absw, absw_sel;
    logic signed [21:0] v_meas, v_apply;
    logic [20:0]        absv;
    logic               in_qual, emit_go;
    logic [REM_W:0]     nr_sum;
    logic [REM_W-1:0]   nr;
    logic [20:0]        nq;
    logic signed [SUM_W+1:0] sum_ext;
    logic [64:0]        sq_ext;
    logic [127:0]       p128;
    logic [63:0]        mag64;

    mvbw_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(prod));

    mvbw_div #(.DIVISOR(DIV_D), .REM_W(REM_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_span(span),
        .o_done(div_done), .o_quo(div_quo), .o_rem(div_rem)
    );

    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign span_raw        = 21'(r_we) - 21'(r_ws);
    assign span            = (span_raw < 21'sd6554) ? WGT_W'(MIN_SPAN) : span_raw[WGT_W-1:0];
    assign in_qual = i_s_axis_tdata[32]
                  && ({1'b0, i_s_axis_tdata[15:0]} >= r_lo)
                  && ({1'b0, i_s_axis_tdata[15:0]} <  r_hi)
                  && !r_cnt[CNT_W-1];
    assign emit_go = !r_out_valid || i_m_axis_tready;

    assign diff     = $signed({1'b0, r_a}) - $signed({1'b0, r_b});
    assign absd     = diff[16] ? 17'(-diff) : 17'(diff);
    assign absw     = r_w[WGT_W-1] ? WGT_W'(-r_w) : WGT_W'(r_w);
    assign absw_sel = r_sel_w[WGT_W-1] ? WGT_W'(-r_sel_w) : WGT_W'(r_sel_w);
    assign v_meas   = blend(r_b, prod, r_neg);
    assign v_apply  = v_meas;
    assign absv     = v_meas[21] ? 21'(-v_meas) : 21'(v_meas);

    assign rs_eff = r_rv ? r_rs : '0;
    assign rq_eff = r_rv ? r_rq : '0;
    assign sum_ext = $signed({rs_eff[SUM_W-1], rs_eff[SUM_W-1], rs_eff}) + (SUM_W + 2)'(r_v);
    assign wr_sum  = (sum_ext > (SUM_W + 2)'(SUM_HI)) ? SUM_HI[SUM_W-1:0] :
                     (sum_ext < (SUM_W + 2)'(SUM_LO)) ? SUM_LO[SUM_W-1:0] :
                     sum_ext[SUM_W-1:0];
    assign sq_ext  = {1'b0, rq_eff} + {1'b0, prod};
    assign wr_sq   = sq_ext[64] ? '1 : sq_ext[63:0];

    assign p128   = {64'd0, prod};
    assign mag64  = 64'(r_mag);
    assign spread = r_acc[ACC_W-1] ? '0 : r_acc[ACC_W-2:0];
    assign better = (r_k == '0) || (spread < r_best);

    // incremental floor(span*k/(steps-1))
    assign nr_sum = {1'b0, r_wr} + {1'b0, r_r0};
    assign nr     = (nr_sum >= (REM_W + 1)'(DIV_D)) ? REM_W'(nr_sum - (REM_W + 1)'(DIV_D))
                                                    : nr_sum[REM_W-1:0];
    assign nq     = r_wq + 21'(r_q0) + 21'(nr_sum >= (REM_W + 1)'(DIV_D));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = (t_req'(i_s_axis_tuser) == REQ_APPLY) ? ST_APROD : ST_DIV;
                end
            end
            ST_DIV:   if (div_done) n_state = r_qual ? ST_MPROD : ST_MEND;
            ST_MPROD: n_state = ST_MSQ;
            ST_MSQ:   n_state = ST_MWR;
            ST_MWR:   n_state = (r_k == K_LAST) ? ST_MEND : ST_MPROD;
            ST_MEND: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (r_cnt == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SRD;
                end
            end
            ST_SRD:   n_state = ST_S0;
            ST_S0:    n_state = ST_S1;
            ST_S1:    n_state = ST_S2;
            ST_S2:    n_state = ST_S3;
            ST_S3:    n_state = ST_S4;
            ST_S4:    n_state = ST_S5;
            ST_S5:    n_state = ST_SCMP;
            ST_SCMP:  n_state = (r_k == K_LAST) ? ST_EMIT : ST_SRD;
            ST_APROD: n_state = ST_ABLD;
            ST_ABLD:  n_state = ST_EMIT;
            ST_EMIT:  if (emit_go) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // unit and memory control
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        div_start = s_acc && (t_req'(i_s_axis_tuser) == REQ_MEASURE);
        unique case (r_state)
            ST_MPROD: begin
                mul_a = MUL_W'(absd);
                mul_b = MUL_W'(absw);
                rd_en = 1'b1;
            end
            ST_MSQ: begin
                mul_a = MUL_W'(absv);
                mul_b = MUL_W'(absv);
            end
            ST_MWR:   wr_en = 1'b1;
            ST_SRD:   rd_en = 1'b1;
            ST_S0: begin
                mul_a = MUL_W'(r_cnt);
                mul_b = rq_eff[31:0];
            end
            ST_S1: begin
                mul_a = MUL_W'(r_cnt);
                mul_b = rq_eff[63:32];
            end
            ST_S2: begin
                mul_a = mag64[31:0];
                mul_b = mag64[31:0];
            end
            ST_S3: begin
                mul_a = mag64[31:0];
                mul_b = mag64[63:32];
            end
            ST_S4: begin
                mul_a = mag64[63:32];
                mul_b = mag64[63:32];
            end
            ST_APROD: begin
                mul_a = MUL_W'(absd);
                mul_b = MUL_W'(absw_sel);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rs <= mem_sum[r_k];
            r_rq <= mem_sq[r_k];
            r_rv <= r_vld[r_k];
        end
        if (wr_en) begin
            mem_sum[r_k] <= wr_sum;
            mem_sq[r_k]  <= wr_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lo        <= '0;
            r_hi        <= RANGE_W'(Q_ONE);
            r_ws        <= '0;
            r_we        <= WGT_W'(Q_ONE);
            r_cnt       <= '0;
            r_vld       <= '0;
            r_sel_w     <= WGT_W'(Q_ONE);
            r_q0        <= '0;
            r_r0        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_RANGE_LOW:    r_lo <= i_cfg_data[RANGE_W-1:0];
                    CFG_RANGE_HIGH:   r_hi <= i_cfg_data[RANGE_W-1:0];
                    CFG_WEIGHT_START: r_ws <= i_cfg_data;
                    CFG_WEIGHT_END:   r_we <= i_cfg_data;
                endcase
            end
            if (s_acc && (t_req'(i_s_axis_tuser) == REQ_MEASURE) && in_qual) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_state == ST_DIV && div_done) begin
                r_q0 <= div_quo;
                r_r0 <= div_rem;
            end
            if (r_state == ST_MWR) begin
                r_vld[r_k] <= 1'b1;
            end
            if (r_state == ST_EMIT && emit_go) begin
                r_out_valid <= 1'b1;
                if (r_res_kind == KIND_REPORT) begin
                    r_sel_w <= r_res_w;
                    r_vld   <= '0;
                    r_cnt   <= '0;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end

        // payload and datapath
        unique case (r_state)
            ST_IDLE: begin
                r_a    <= i_s_axis_tdata[15:0];
                r_b    <= i_s_axis_tdata[31:16];
                r_last <= i_s_axis_tlast;
                r_qual <= in_qual;
            end
            ST_DIV: begin
                r_k  <= '0;
                r_wq <= '0;
                r_wr <= '0;
                r_w  <= sat_weight(r_ws, 21'd0);
            end
            ST_MPROD: begin
                r_neg <= diff[16] ^ r_w[WGT_W-1];
                r_wq  <= nq;
                r_wr  <= nr;
                r_w   <= sat_weight(r_ws, nq);
            end
            ST_MSQ:  r_v <= v_meas;
            ST_MWR:  r_k <= r_k + K_W'(1);
            ST_MEND: begin
                r_k         <= '0;
                r_wq        <= '0;
                r_wr        <= '0;
                r_w         <= sat_weight(r_ws, 21'd0);
                r_res_kind  <= KIND_REPORT;
                r_res_blend <= '0;
                r_res_w     <= WGT_W'(Q_ONE);
                r_res_idx   <= IDX_W'(WEIGHT_STEPS);
            end
            ST_S0: r_mag <= rs_eff[SUM_W-1] ? SUM_W'(-$signed(rs_eff)) : rs_eff;
            ST_S1: r_acc <= ACC_W'(prod);
            ST_S2: r_acc <= r_acc + $signed(ACC_W'(p128 << 32));
            ST_S3: r_acc <= r_acc - $signed(p128[ACC_W-1:0]);
            ST_S4: r_acc <= r_acc - $signed(ACC_W'(p128 << 33));
            ST_S5: r_acc <= r_acc - $signed(ACC_W'(p128 << 64));
            ST_SCMP: begin
                if (better) begin
                    r_best   <= spread;
                    r_best_k <= r_k;
                    r_best_w <= r_w;
                end
                r_res_w   <= better ? r_w : r_best_w;
                r_res_idx <= IDX_W'(better ? r_k : r_best_k);
                r_wq      <= nq;
                r_wr      <= nr;
                r_w       <= sat_weight(r_ws, nq);
                r_k       <= r_k + K_W'(1);
            end
            ST_APROD: r_neg <= diff[16] ^ r_sel_w[WGT_W-1];
            ST_ABLD: begin
                r_res_kind <= KIND_BLEND;
                r_res_w    <= r_sel_w;
                r_res_idx  <= '0;
                if (v_apply[21]) begin
                    r_res_blend <= '0;
                end else if (v_apply > PIX_MAX) begin
                    r_res_blend <= PIX_MAX[VAL_W-1:0];
                end else begin
                    r_res_blend <= v_apply[VAL_W-1:0];
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    r_out_kind  <= r_res_kind;
                    r_out_blend <= r_res_blend;
                    r_out_w     <= r_res_w;
                    r_out_idx   <= r_res_idx;
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = OUT_W'({r_out_idx, r_out_w, r_out_blend});
endmodule

// File: rtl/mvbw_chk.sv
// Port-level checker of the blend weight block, bound to the top level.
module mvbw_chk #(
    parameter int WEIGHT_STEPS = mvbw_pkg::WEIGHT_STEPS_DEF,
    parameter int IDX_W        = $clog2(WEIGHT_STEPS + 1),
    parameter int OUT_W        = ((36 + IDX_W + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tuser
);
    import mvbw_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result changed while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request taken while busy");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[36 +: IDX_W] <= IDX_W'(WEIGHT_STEPS)))
        else $error("chosen index out of range");

    a_blend_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (t_kind'(o_m_axis_tuser) == KIND_BLEND))
            |-> (o_m_axis_tdata[36 +: IDX_W] == '0))
        else $error("blend result carries an index");
endmodule

bind min_variance_blend_weight mvbw_chk #(.WEIGHT_STEPS(WEIGHT_STEPS)) u_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata(o_m_axis_tdata),
    .o_m_axis_tuser(o_m_axis_tuser)
);
